// File: rtl/core/pic_pkg.sv
// shared types, constants and address map of the platform interrupt controller
package pic_pkg;

	localparam int unsigned SOURCES_DEF       = 64;
	localparam int unsigned PRIORITY_BITS_DEF = 3;
	localparam int unsigned LEVEL_LINES       = 64;

	localparam logic [21:0] ENABLE_BASE    = 22'h002000;
	localparam logic [21:0] THRESHOLD_ADDR = 22'h200000;
	localparam logic [21:0] CLAIM_ADDR     = 22'h200004;
	localparam int unsigned WORD_BYTES     = 4;
	localparam int unsigned BITS_PER_WORD  = 32;

	typedef enum logic [1:0] {
		OP_READ   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_SAMPLE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// decoded register targets
	typedef enum logic [2:0] {
		TGT_PRIO,
		TGT_ENABLE,
		TGT_THRESH,
		TGT_CLAIM,
		TGT_ERROR
	} target_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_CLAIM,
		ST_FINAL,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture a beat
		logic exec;       // apply access or sample
		logic scan_start; // reset the priority scan
		logic scan_step;  // one source per cycle
		logic claim;      // take the claim result
		logic finish;     // register the interrupt request
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
		logic is_claim_read;
	} status_t;

endpackage

// File: rtl/core/pic_if.sv
// valid/ready channel interfaces for the interrupt controller
interface pic_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [21:0] address;
	logic [31:0] write_data;
	logic [63:0] source_levels;
	modport source (output valid, operation, address, write_data, source_levels, input ready);
	modport sink (input valid, operation, address, write_data, source_levels, output ready);
endinterface

interface pic_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic        access_error;
	logic        interrupt_request;
	modport source (output valid, read_data, access_error, interrupt_request, input ready);
	modport sink (input valid, read_data, access_error, interrupt_request, output ready);
endinterface

// File: rtl/core/platform_interrupt_controller.sv
// top level of the single-context platform interrupt controller
// sequence: an ordinary beat passes EXEC, a serial scan in FINAL and OUT; a claim read
// also scans in SCAN and takes CLAIM before FINAL; the scan covers one source per cycle
// throughput: one beat at a time; next input taken the cycle after the result beat
// reset: arst_n clears priorities, enables, threshold, pending and in-service bits
module platform_interrupt_controller #(
	parameter int unsigned SOURCES       = pic_pkg::SOURCES_DEF,
	parameter int unsigned PRIORITY_BITS = pic_pkg::PRIORITY_BITS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	pic_in_if.sink   in_ch,
	pic_out_if.source out_ch
);

	pic_pkg::cmd_t    cmd;
	pic_pkg::status_t sts;

	pic_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd)
	);

	pic_dp #(.SOURCES(SOURCES), .PRIORITY_BITS(PRIORITY_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.operation(in_ch.operation), .address(in_ch.address),
		.write_data(in_ch.write_data), .source_levels(in_ch.source_levels),
		.read_data(out_ch.read_data), .access_error(out_ch.access_error),
		.interrupt_request(out_ch.interrupt_request)
	);

endmodule

// File: rtl/core/pic_ctrl.sv
// sequencing state machine of the interrupt controller
module pic_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  pic_pkg::status_t sts,
	output pic_pkg::cmd_t    cmd
);

	pic_pkg::state_t state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pic_pkg::ST_IDLE: if (in_valid) state_d = pic_pkg::ST_EXEC;
			pic_pkg::ST_EXEC: state_d = sts.is_claim_read ? pic_pkg::ST_SCAN : pic_pkg::ST_FINAL;
			pic_pkg::ST_SCAN: if (sts.scan_done) state_d = pic_pkg::ST_CLAIM;
			pic_pkg::ST_CLAIM: state_d = pic_pkg::ST_FINAL;
			pic_pkg::ST_FINAL: if (sts.scan_done) state_d = pic_pkg::ST_OUT;
			pic_pkg::ST_OUT: if (out_ready) state_d = pic_pkg::ST_IDLE;
			default: state_d = pic_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			pic_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			pic_pkg::ST_EXEC: begin
				cmd.exec       = 1'b1;
				cmd.scan_start = 1'b1;
			end
			pic_pkg::ST_SCAN: cmd.scan_step = 1'b1;
			pic_pkg::ST_CLAIM: begin
				cmd.claim      = 1'b1;
				cmd.scan_start = 1'b1;
			end
			pic_pkg::ST_FINAL: begin
				cmd.scan_step = 1'b1;
				cmd.finish    = sts.scan_done;
			end
			pic_pkg::ST_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= pic_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("input and output open together");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_load_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.exec) else $error("beat not executed");

endmodule

// File: rtl/core/pic_dp.sv
// register file, gateways and sequential priority scan
module pic_dp #(
	parameter int unsigned SOURCES       = pic_pkg::SOURCES_DEF,
	parameter int unsigned PRIORITY_BITS = pic_pkg::PRIORITY_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  pic_pkg::cmd_t    cmd,
	output pic_pkg::status_t sts,
	input  logic [1:0]       operation,
	input  logic [21:0]      address,
	input  logic [31:0]      write_data,
	input  logic [63:0]      source_levels,
	output logic [31:0]      read_data,
	output logic             access_error,
	output logic             interrupt_request
);

	localparam int unsigned IDW   = $clog2(SOURCES);
	localparam int unsigned WORDS = (SOURCES + pic_pkg::BITS_PER_WORD - 1) / pic_pkg::BITS_PER_WORD;
	localparam int unsigned WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int unsigned EBITS = WORDS * pic_pkg::BITS_PER_WORD;

	// captured beat
	pic_pkg::op_t op_q;
	logic [21:0]  addr_q;
	logic [31:0]  data_q;
	logic [63:0]  lev_q;

	logic [PRIORITY_BITS-1:0] prio_q [SOURCES];
	logic [EBITS-1:0]         en_q;
	logic [PRIORITY_BITS-1:0] thr_q;
	logic [SOURCES-1:0]       pend_q, insv_q;

	// scan registers
	logic [IDW:0]             scan_id_q;
	logic [IDW-1:0]           best_q;
	logic [PRIORITY_BITS-1:0] best_prio_q;
	logic                     found_q;

	logic [31:0] rd_q;
	logic        err_q;

	// address decode
	pic_pkg::target_t tgt;
	logic [IDW-1:0]   prio_idx;
	logic [WW-1:0]    en_word;
	logic [21:0]      en_off;
	logic [31:0]      en_rd, wmask;
	always_comb begin
		en_off   = addr_q - pic_pkg::ENABLE_BASE;
		prio_idx = addr_q[IDW+1:2];
		en_word  = WW'(en_off >> 2);
		if (addr_q[1:0] != 2'b00) tgt = pic_pkg::TGT_ERROR;
		else if (32'(addr_q) < SOURCES * pic_pkg::WORD_BYTES) tgt = pic_pkg::TGT_PRIO;
		else if (addr_q >= pic_pkg::ENABLE_BASE &&
			32'(en_off) < WORDS * pic_pkg::WORD_BYTES) tgt = pic_pkg::TGT_ENABLE;
		else if (addr_q == pic_pkg::THRESHOLD_ADDR) tgt = pic_pkg::TGT_THRESH;
		else if (addr_q == pic_pkg::CLAIM_ADDR) tgt = pic_pkg::TGT_CLAIM;
		else tgt = pic_pkg::TGT_ERROR;
		en_rd = en_q[en_word*pic_pkg::BITS_PER_WORD +: pic_pkg::BITS_PER_WORD];
		for (int b = 0; b < 32; b++)
			wmask[b] = (32'(en_word) * 32 + 32'(b) < SOURCES) && !(en_word == '0 && b == 0);
	end

	logic done_id;
	logic cmp_id_ok;
	assign cmp_id_ok = (data_q != '0) && (data_q < 32'(SOURCES));
	assign done_id   = cmp_id_ok && en_q[data_q[IDW-1:0]];

	// scan starts from the threshold as it stands after this beat
	logic [PRIORITY_BITS-1:0] thr_start;
	assign thr_start = (cmd.exec && op_q == pic_pkg::OP_WRITE && tgt == pic_pkg::TGT_THRESH) ?
		data_q[PRIORITY_BITS-1:0] : thr_q;

	// one source per scan step
	logic [IDW-1:0] cur;
	logic           hit;
	assign cur = scan_id_q[IDW-1:0];
	assign hit = pend_q[cur] && en_q[cur] && (prio_q[cur] > best_prio_q) && (cur != '0);
	assign sts.scan_done     = (scan_id_q == (IDW+1)'(SOURCES));
	assign sts.is_claim_read = (op_q == pic_pkg::OP_READ) && (tgt == pic_pkg::TGT_CLAIM);

	// beat capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= pic_pkg::op_t'(operation);
			addr_q <= address;
			data_q <= write_data;
			lev_q  <= source_levels;
		end
	end

	// priority scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_id_q   <= '0;
			best_q      <= '0;
			best_prio_q <= '0;
			found_q     <= 1'b0;
		end else if (cmd.scan_start) begin
			scan_id_q   <= '0;
			best_q      <= '0;
			best_prio_q <= thr_start;
			found_q     <= 1'b0;
		end else if (cmd.scan_step && !sts.scan_done) begin
			scan_id_q <= scan_id_q + 1'b1;
			if (hit) begin
				best_q      <= cur;
				best_prio_q <= prio_q[cur];
				found_q     <= 1'b1;
			end
		end
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SOURCES; i++) prio_q[i] <= '0;
			en_q   <= '0;
			thr_q  <= '0;
			pend_q <= '0;
			insv_q <= '0;
		end else begin
			if (cmd.exec) begin
				if (op_q == pic_pkg::OP_SAMPLE) begin
					for (int i = 1; i < SOURCES; i++)
						if (i < pic_pkg::LEVEL_LINES && lev_q[i] && !insv_q[i]) pend_q[i] <= 1'b1;
				end else if (op_q == pic_pkg::OP_WRITE) begin
					case (tgt)
						pic_pkg::TGT_PRIO:
							if (prio_idx != '0) prio_q[prio_idx] <= data_q[PRIORITY_BITS-1:0];
						pic_pkg::TGT_ENABLE:
							en_q[en_word*pic_pkg::BITS_PER_WORD +: pic_pkg::BITS_PER_WORD]
								<= data_q & wmask;
						pic_pkg::TGT_THRESH: thr_q <= data_q[PRIORITY_BITS-1:0];
						pic_pkg::TGT_CLAIM: if (done_id) insv_q[data_q[IDW-1:0]] <= 1'b0;
						default: ;
					endcase
				end
			end
			if (cmd.claim && found_q) begin
				pend_q[best_q] <= 1'b0;
				insv_q[best_q] <= 1'b1;
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rd_q  <= '0;
			err_q <= 1'b0;
			if (op_q == pic_pkg::OP_READ || op_q == pic_pkg::OP_WRITE) begin
				err_q <= (tgt == pic_pkg::TGT_ERROR);
				if (op_q == pic_pkg::OP_READ)
					case (tgt)
						pic_pkg::TGT_PRIO: rd_q <= 32'(prio_q[prio_idx]);
						pic_pkg::TGT_ENABLE: rd_q <= en_rd;
						pic_pkg::TGT_THRESH: rd_q <= 32'(thr_q);
						default: ;
					endcase
			end
		end
		if (cmd.claim) rd_q <= found_q ? 32'(best_q) : '0;
		if (cmd.finish) interrupt_request <= found_q;
	end

	assign read_data    = rd_q;
	assign access_error = err_q;

	a_claim_set: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.claim && found_q |=> insv_q[$past(best_q)] && !pend_q[$past(best_q)])
		else $error("claim did not move source to service");
	a_zero_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!pend_q[0] && !insv_q[0]) else $error("source zero active");
	a_best_over: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> best_prio_q > thr_q) else $error("claim under threshold");

endmodule

// File: bench/tb_top.sv
// self-checking testbench for the platform interrupt controller
`timescale 1ns / 1ps

module tb_top;
	import pic_pkg::*;

	localparam int unsigned NSRC  = SOURCES_DEF;
	localparam int unsigned PBITS = PRIORITY_BITS_DEF;
	localparam logic [31:0] PMASK = (32'd1 << PBITS) - 1;

	typedef struct packed {
		op_t         operation;
		logic [21:0] address;
		logic [31:0] write_data;
		logic [63:0] source_levels;
	} access_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        access_error;
		logic        interrupt_request;
	} response_t;

	// directed row: beat plus an optional typed-in response
	typedef struct packed {
		access_t   beat;
		logic      known;
		response_t resp;
	} row_t;

	logic clk;
	logic arst_n;
	pic_in_if  in_ch ();
	pic_out_if out_ch ();

	platform_interrupt_controller i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	// shadow copy of the controller state
	logic [PBITS-1:0] shadow_prio [NSRC];
	logic [NSRC-1:0]  shadow_enable;
	logic [PBITS-1:0] shadow_threshold;
	logic [NSRC-1:0]  shadow_pending;
	logic [NSRC-1:0]  shadow_in_service;

	response_t awaited_responses [$];
	int        failures;
	int        beats_sent;
	int        responses_seen;
	int        claims_granted;
	int        send_idle_pct;
	int        recv_idle_pct;
	bit        recv_hold;

	// clock; reset is driven from the main initial block
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] enable_word_mask(int unsigned w);
		logic [31:0] m;
		m = 32'hFFFF_FFFF;
		if (NSRC - w * 32 < 32)
			m = (32'd1 << (NSRC - w * 32)) - 1;
		if (w == 0)
			m[0] = 1'b0;
		return m;
	endfunction

	// highest-priority enabled pending source above threshold, 0 if none
	function automatic int unsigned winning_source();
		int unsigned best;
		logic [PBITS-1:0] best_prio;
		best = 0;
		best_prio = shadow_threshold;
		for (int unsigned id = 1; id < NSRC; id++) begin
			if (shadow_pending[id] && shadow_enable[id] && shadow_prio[id] > best_prio) begin
				best = id;
				best_prio = shadow_prio[id];
			end
		end
		return best;
	endfunction

	// apply one beat to the shadow state and return the response
	function automatic response_t predict_access(access_t b);
		response_t r;
		int unsigned w;
		int unsigned id;
		r = '0;
		if (b.operation == OP_SAMPLE) begin
			for (int unsigned i = 1; i < NSRC; i++)
				if (i < LEVEL_LINES && b.source_levels[i] && !shadow_pending[i]
						&& !shadow_in_service[i])
					shadow_pending[i] = 1'b1;
		end else if (b.operation == OP_READ || b.operation == OP_WRITE) begin
			if (b.address[1:0] != 2'b00) begin
				r.access_error = 1'b1;
			end else if (b.address < NSRC * WORD_BYTES) begin
				id = b.address / WORD_BYTES;
				if (b.operation == OP_WRITE) begin
					if (id != 0)
						shadow_prio[id] = b.write_data[PBITS-1:0];
				end else begin
					r.read_data = 32'(shadow_prio[id]);
				end
			end else if (b.address >= ENABLE_BASE
					&& b.address < ENABLE_BASE + ((NSRC + 31) / 32) * WORD_BYTES) begin
				w = (b.address - ENABLE_BASE) / WORD_BYTES;
				if (b.operation == OP_WRITE)
					shadow_enable[w*32 +: 32] = b.write_data & enable_word_mask(w);
				else
					r.read_data = shadow_enable[w*32 +: 32];
			end else if (b.address == THRESHOLD_ADDR) begin
				if (b.operation == OP_WRITE)
					shadow_threshold = b.write_data[PBITS-1:0];
				else
					r.read_data = 32'(shadow_threshold);
			end else if (b.address == CLAIM_ADDR) begin
				if (b.operation == OP_WRITE) begin
					if (b.write_data != 0 && b.write_data < NSRC
							&& shadow_enable[b.write_data])
						shadow_in_service[b.write_data] = 1'b0;
				end else begin
					id = winning_source();
					r.read_data = id;
					if (id != 0) begin
						shadow_pending[id] = 1'b0;
						shadow_in_service[id] = 1'b1;
						claims_granted++;
					end
				end
			end else begin
				r.access_error = 1'b1;
			end
		end
		r.interrupt_request = winning_source() != 0;
		return r;
	endfunction

	function automatic access_t make_access(op_t op, logic [21:0] addr, logic [31:0] data,
			logic [63:0] levels);
		access_t b;
		b.operation = op;
		b.address = addr;
		b.write_data = data;
		b.source_levels = levels;
		return b;
	endfunction

	// random beat, mostly well-formed register traffic and claim/complete cycles
	function automatic access_t random_access();
		access_t b;
		int unsigned pick;
		b = make_access(OP_READ, 22'($urandom), $urandom, {$urandom, $urandom});
		pick = $urandom_range(0, 99);
		if (pick < 18) begin
			b.operation = op_t'($urandom_range(0, 1));
			b.address = 22'($urandom_range(0, NSRC - 1) * 4);
			if ($urandom_range(0, 3) != 0)
				b.write_data = $urandom_range(0, 7);
		end else if (pick < 28) begin
			b.operation = op_t'($urandom_range(0, 1));
			b.address = ENABLE_BASE + 22'($urandom_range(0, 1) * 4);
			if ($urandom_range(0, 1) == 0)
				b.write_data = 32'hFFFF_FFFF;
		end else if (pick < 34) begin
			b.operation = op_t'($urandom_range(0, 1));
			b.address = THRESHOLD_ADDR;
			b.write_data = $urandom_range(0, 3);
		end else if (pick < 52) begin
			b.operation = OP_SAMPLE;
		end else if (pick < 70) begin
			b.operation = OP_READ;
			b.address = CLAIM_ADDR;
		end else if (pick < 86) begin
			b.operation = OP_WRITE;
			b.address = CLAIM_ADDR;
			if ($urandom_range(0, 7) != 0)
				b.write_data = $urandom_range(0, NSRC);
		end else if (pick < 90) begin
			b.operation = OP_NONE;
		end else if (pick < 94) begin
			b.operation = op_t'($urandom_range(0, 1));
			b.address = 22'($urandom_range(0, 3) * 4 + 2 + $urandom_range(0, 1));
		end
		// otherwise a fully random address, nearly always unmapped
		return b;
	endfunction

	// offer one beat and wait for acceptance
	task automatic send_access(access_t b, logic known, response_t resp);
		response_t predicted;
		while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.operation     <= b.operation;
		in_ch.address       <= b.address;
		in_ch.write_data    <= b.write_data;
		in_ch.source_levels <= b.source_levels;
		do
			@(posedge clk);
		while (!in_ch.ready);
		predicted = predict_access(b);
		if (known && predicted != resp) begin
			$display("%0t: table row disagrees with prediction: table %h predicted %h",
				$time, resp, predicted);
			failures++;
		end
		awaited_responses.push_back(predicted);
		beats_sent++;
	endtask

	// settle until every response is in, with the latency margin after
	task automatic drain_responses();
		in_ch.valid <= 1'b0;
		while (awaited_responses.size() != 0)
			@(posedge clk);
		repeat (2 * NSRC + 10) @(posedge clk);
	endtask

	// receiver: random stalls, optionally a long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= !recv_hold && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// response checker
	always @(posedge clk) begin
		response_t got;
		response_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.read_data = out_ch.read_data;
			got.access_error = out_ch.access_error;
			got.interrupt_request = out_ch.interrupt_request;
			if (awaited_responses.size() == 0) begin
				$display("%0t: response with none outstanding: actual %h", $time, got);
				failures++;
			end else begin
				want = awaited_responses.pop_front();
				responses_seen++;
				if (got.read_data !== want.read_data) begin
					$display("%0t: read_data mismatch: expected %h actual %h",
						$time, want.read_data, got.read_data);
					failures++;
				end
				if (got.access_error !== want.access_error) begin
					$display("%0t: access_error mismatch: expected %b actual %b",
						$time, want.access_error, got.access_error);
					failures++;
				end
				if (got.interrupt_request !== want.interrupt_request) begin
					$display("%0t: interrupt_request mismatch: expected %b actual %b",
						$time, want.interrupt_request, got.interrupt_request);
					failures++;
				end
			end
		end
	end

	// directed table
	row_t steering_rows [$];

	initial begin
		response_t none;
		response_t err;
		access_t   b;
		none = '0;
		err = '0;
		err.access_error = 1'b1;
		failures = 0;
		beats_sent = 0;
		responses_seen = 0;
		claims_granted = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		recv_hold = 1'b0;
		shadow_prio = '{default: '0};
		shadow_enable = '0;
		shadow_threshold = '0;
		shadow_pending = '0;
		shadow_in_service = '0;
		in_ch.valid = 1'b0;
		in_ch.operation = OP_READ;
		in_ch.address = '0;
		in_ch.write_data = '0;
		in_ch.source_levels = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, extremes, error cases, claim and complete
		steering_rows = '{
			'{make_access(OP_READ, 22'd4, 0, 0), 1'b1, none},
			'{make_access(OP_READ, CLAIM_ADDR, 0, 0), 1'b1, none},
			'{make_access(OP_WRITE, 22'd0, 32'hFFFF_FFFF, 0), 1'b1, none},
			'{make_access(OP_READ, 22'd0, 0, 0), 1'b1, none},
			'{make_access(OP_WRITE, 22'd4, 32'hFFFF_FFFF, 0), 1'b1, none},
			'{make_access(OP_READ, 22'd4, 0, 0), 1'b1, '{32'(PMASK), 1'b0, 1'b0}},
			'{make_access(OP_WRITE, 22'(4 * (NSRC - 1)), 32'd5, 0), 1'b0, none},
			'{make_access(OP_READ, 22'(4 * NSRC), 0, 0), 1'b1, err},
			'{make_access(OP_WRITE, 22'd6, 0, 0), 1'b1, err},
			'{make_access(OP_READ, 22'd1, 0, 0), 1'b1, err},
			'{make_access(OP_READ, 22'h3F_FFFC, 0, 0), 1'b1, err},
			'{make_access(OP_WRITE, ENABLE_BASE + 22'd8, 0, 0), 1'b1, err},
			'{make_access(OP_WRITE, ENABLE_BASE, 32'hFFFF_FFFF, 0), 1'b1, none},
			'{make_access(OP_READ, ENABLE_BASE, 0, 0), 1'b1, '{32'hFFFF_FFFE, 1'b0, 1'b0}},
			'{make_access(OP_WRITE, ENABLE_BASE + 22'd4, 32'hFFFF_FFFF, 0), 1'b0, none},
			'{make_access(OP_WRITE, THRESHOLD_ADDR, 32'hFFFF_FFF9, 0), 1'b0, none},
			'{make_access(OP_READ, THRESHOLD_ADDR, 0, 0), 1'b1, '{32'd1, 1'b0, 1'b0}},
			'{make_access(OP_SAMPLE, 22'h3F_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF),
				1'b0, none},
			'{make_access(OP_NONE, 22'h3F_FFFF, 32'hFFFF_FFFF, 0), 1'b0, none},
			'{make_access(OP_READ, CLAIM_ADDR, 0, 0), 1'b0, none},
			'{make_access(OP_READ, CLAIM_ADDR, 0, 0), 1'b0, none},
			'{make_access(OP_WRITE, CLAIM_ADDR, 32'd0, 0), 1'b0, none},
			'{make_access(OP_WRITE, CLAIM_ADDR, 32'(NSRC), 0), 1'b0, none},
			'{make_access(OP_WRITE, CLAIM_ADDR, 32'd1, 0), 1'b0, none},
			'{make_access(OP_WRITE, THRESHOLD_ADDR, 32'd0, 0), 1'b0, none}
		};
		foreach (steering_rows[i])
			send_access(steering_rows[i].beat, steering_rows[i].known, steering_rows[i].resp);
		drain_responses();

		// random traffic in three idling phases
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 80 : 0;
			recv_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 10 : 0;
			for (int n = 0; n < 210; n++) begin
				b = random_access();
				send_access(b, 1'b0, none);
			end
		end

		// long receiver hold-off while beats keep coming
		fork
			begin
				recv_hold = 1'b1;
				repeat (1000) @(posedge clk);
				recv_hold = 1'b0;
			end
			for (int n = 0; n < 8; n++)
				send_access(random_access(), 1'b0, none);
		join
		drain_responses();

		$display("%0d beats sent, %0d responses checked, %0d claims granted",
			beats_sent, responses_seen, claims_granted);
		if (failures == 0)
			$display("platform_interrupt_controller test passed");
		else
			$display("platform_interrupt_controller test failed");
		$finish;
	end

	// watchdog
	initial begin
		#30ms;
		$display("platform_interrupt_controller test failed");
		$finish;
	end

endmodule

// File: platform_interrupt_controller.f
rtl/core/pic_pkg.sv
rtl/core/pic_if.sv
rtl/core/pic_ctrl.sv
rtl/core/pic_dp.sv
rtl/core/platform_interrupt_controller.sv
bench/tb_top.sv
